// ===== sv/ltc_pkg.sv =====
`timescale 1ns / 1ps

package ltc_pkg;

   // Wide enough for the largest supported slot count (64)
   localparam int SLOT_IDX_W = 6;
   localparam int TAG_W      = 32;
   localparam int STAMP_W    = 32;

   // Search word passed from cell to cell
   typedef struct packed {
      logic [TAG_W-1:0]      tag;
      logic                  fill_ok;
      logic                  hit;
      logic [SLOT_IDX_W-1:0] hit_idx;
      logic                  empty;
      logic [SLOT_IDX_W-1:0] empty_idx;
      logic [STAMP_W-1:0]    min_stamp;
      logic [SLOT_IDX_W-1:0] min_idx;
   } ltc_token_type;

   // Write broadcast to all cells once the decision is made
   typedef struct packed {
      logic                  en;
      logic [SLOT_IDX_W-1:0] idx;
      logic                  wr_valid;
      logic                  valid_val;
      logic                  wr_tag;
      logic                  wr_stamp;
      logic [TAG_W-1:0]      tag;
      logic [STAMP_W-1:0]    stamp;
   } ltc_update_type;

endpackage

// ===== sv/ltc_cell.sv =====
`timescale 1ns / 1ps

// One cache slot: holds valid, tag and stamp, and folds its entry into the
// search word before handing it on to the next cell.
module ltc_cell import ltc_pkg::*; #(
   parameter logic [SLOT_IDX_W-1:0] IDX = '0
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           tok_vld_i,
   input  ltc_token_type  tok_i,
   input  ltc_update_type upd_i,
   output logic           tok_vld_o,
   output ltc_token_type  tok_o
);

   logic               valid_ff, valid_in;
   logic [TAG_W-1:0]   tag_ff, tag_in;
   logic [STAMP_W-1:0] stamp_ff, stamp_in;
   logic               tok_vld_ff;
   ltc_token_type      tok_ff, tok_in;
   logic               sel;

   always_comb begin
      sel      = upd_i.en && (upd_i.idx == IDX);
      valid_in = valid_ff;
      tag_in   = tag_ff;
      stamp_in = stamp_ff;
      if (sel) begin
         if (upd_i.wr_valid) valid_in = upd_i.valid_val;
         if (upd_i.wr_tag)   tag_in   = upd_i.tag;
         if (upd_i.wr_stamp) stamp_in = upd_i.stamp;
      end

      tok_in = tok_i;
      if (!tok_i.hit && valid_ff && (tag_ff == tok_i.tag)) begin
         tok_in.hit     = 1'b1;
         tok_in.hit_idx = IDX;
      end
      if (!tok_i.empty && !valid_ff) begin
         tok_in.empty     = 1'b1;
         tok_in.empty_idx = IDX;
      end
      // first cell seeds the minimum; strict compare keeps lowest index on ties
      if ((IDX == '0) || (stamp_ff < tok_i.min_stamp)) begin
         tok_in.min_stamp = stamp_ff;
         tok_in.min_idx   = IDX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         tok_vld_ff <= 1'b0;
      end else begin
         valid_ff   <= valid_in;
         tok_vld_ff <= tok_vld_i;
      end
      tag_ff   <= tag_in;
      stamp_ff <= stamp_in;
      tok_ff   <= tok_in;
   end

   assign tok_vld_o = tok_vld_ff;
   assign tok_o     = tok_ff;

endmodule

// ===== sv/lru_tag_cache_lookup_unit.sv =====
`timescale 1ns / 1ps

// Fully associative tag cache, least-recently-used replacement by stamps.
//
// Request channel (req_): one word per lookup, tag in tdata, fill_ok in
// tuser. Result channel (rsp_): one word per lookup with hit, slot index,
// evicted and status.
//
// A lookup passes through the start register, one register per slot cell and
// the tail register; the write-back then loads the output register and raises
// rsp_tvalid. Only one lookup is in flight at a time: req_tready is low from
// acceptance until the write-back and rises on the cycle after it.
//
// The result sits in an output register; the next request is taken while it
// waits. If the receiver stalls, the following result holds in the tail
// register and the write-back waits until the output register frees up.
//
// Reset empties every slot and clears the use counter; tags and stamps are
// not cleared and are only looked at for valid slots.
module lru_tag_cache_lookup_unit import ltc_pkg::*; #(
   parameter int SLOTS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] lookup_tag
   input  logic [0:0]  req_tuser,   // [0] fill_ok
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // [0] hit, [3:1] slot_index, [4] evicted,
                                    // [5] status, [7:6] zero
);

   logic               busy_ff, busy_in;
   logic               start_vld_ff;
   ltc_token_type      start_tok_ff, start_tok_in;
   logic               tail_vld_ff, tail_vld_in;
   ltc_token_type      tail_tok_ff;
   logic               rsp_vld_ff, rsp_vld_in;
   logic [7:0]         rsp_data_ff, rsp_data_in;
   logic [STAMP_W-1:0] use_counter_ff, use_counter_in;

   logic [SLOTS:0]     chain_vld;
   ltc_token_type      chain_tok [SLOTS+1];
   ltc_update_type     upd;

   logic                  accept;
   logic                  decide;
   logic [SLOT_IDX_W-1:0] slot_sel;
   logic                  evict;
   logic                  stat;

   assign req_tready = !busy_ff;
   assign accept     = req_tvalid && req_tready;
   assign decide     = tail_vld_ff && (!rsp_vld_ff || rsp_tready);

   // fresh search word
   always_comb begin
      start_tok_in           = '0;
      start_tok_in.tag       = req_tdata;
      start_tok_in.fill_ok   = req_tuser[0];
   end

   assign chain_vld[0] = start_vld_ff;
   assign chain_tok[0] = start_tok_ff;

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      ltc_cell #(
         .IDX(SLOT_IDX_W'(i))
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .tok_vld_i (chain_vld[i]),
         .tok_i     (chain_tok[i]),
         .upd_i     (upd),
         .tok_vld_o (chain_vld[i+1]),
         .tok_o     (chain_tok[i+1])
      );
   end

   // decision on the word that left the last cell
   always_comb begin
      evict          = !tail_tok_ff.hit && !tail_tok_ff.empty;
      stat           = !tail_tok_ff.hit && !tail_tok_ff.fill_ok;
      slot_sel       = tail_tok_ff.hit   ? tail_tok_ff.hit_idx   :
                       tail_tok_ff.empty ? tail_tok_ff.empty_idx : tail_tok_ff.min_idx;
      use_counter_in = use_counter_ff;

      upd            = '0;
      upd.en         = decide;
      upd.idx        = slot_sel;
      upd.tag        = tail_tok_ff.tag;
      upd.stamp      = use_counter_ff;
      if (tail_tok_ff.hit) begin
         upd.wr_stamp = 1'b1;
      end else if (tail_tok_ff.fill_ok) begin
         upd.wr_valid  = 1'b1;
         upd.valid_val = 1'b1;
         upd.wr_tag    = 1'b1;
         upd.wr_stamp  = 1'b1;
      end else begin
         // failed fill: slot contents already released, leave it empty
         upd.wr_valid  = 1'b1;
         upd.valid_val = 1'b0;
      end
      if (decide && (tail_tok_ff.hit || tail_tok_ff.fill_ok)) begin
         use_counter_in = use_counter_ff + STAMP_W'(1);
      end

      rsp_data_in = {2'b00, stat, evict, slot_sel[2:0], tail_tok_ff.hit};
   end

   always_comb begin
      busy_in = busy_ff;
      if (accept)      busy_in = 1'b1;
      else if (decide) busy_in = 1'b0;

      tail_vld_in = tail_vld_ff;
      if (chain_vld[SLOTS]) tail_vld_in = 1'b1;
      else if (decide)      tail_vld_in = 1'b0;

      rsp_vld_in = rsp_vld_ff;
      if (decide)          rsp_vld_in = 1'b1;
      else if (rsp_tready) rsp_vld_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff        <= 1'b0;
         start_vld_ff   <= 1'b0;
         tail_vld_ff    <= 1'b0;
         rsp_vld_ff     <= 1'b0;
         use_counter_ff <= '0;
      end else begin
         busy_ff        <= busy_in;
         start_vld_ff   <= accept;
         tail_vld_ff    <= tail_vld_in;
         rsp_vld_ff     <= rsp_vld_in;
         use_counter_ff <= use_counter_in;
      end
      if (accept)           start_tok_ff <= start_tok_in;
      if (chain_vld[SLOTS]) tail_tok_ff  <= chain_tok[SLOTS];
      if (decide)           rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

   // at most one search word anywhere in the row
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      $countones({chain_vld, tail_vld_ff}) <= 1)
      else $error("more than one lookup in flight");

   // idle means the row is empty
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> (chain_vld == '0) && !tail_vld_ff)
      else $error("search word present while idle");

   // write-back frees the block for the next request
   a_decide_frees: assert property (@(posedge clock) disable iff (reset)
      decide |=> !busy_ff && rsp_tvalid)
      else $error("write-back did not release the block");

   // a hit never reports eviction or a failed fill
   a_hit_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> !rsp_tdata[4] && !rsp_tdata[5])
      else $error("hit with eviction or failure flag");

   // counter advances only on a successful write-back
   a_counter_step: assert property (@(posedge clock) disable iff (reset)
      !decide |=> $stable(use_counter_ff))
      else $error("use counter moved without a write-back");

endmodule

// ===== verif/lru_tag_cache_lookup_unit_tb.sv =====
`timescale 1ns / 1ps

module lru_tag_cache_lookup_unit_tb;

   localparam int SLOTS       = 8;
   localparam int RANDOM_WORDS = 750;
   localparam int CYCLE_LIMIT = 200000;

   // last member is bit 0, matching the rsp_tdata layout
   typedef struct packed {
      logic       status;
      logic       evicted;
      logic [2:0] slot;
      logic       hit;
   } lookup_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;    // [31:0] lookup_tag
   logic [0:0]  req_tuser = '0;    // [0] fill_ok
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // [0] hit, [3:1] slot_index, [4] evicted, [5] status

   // predictor's copy of the cache
   logic        cache_valid [SLOTS];
   logic [31:0] cache_tag   [SLOTS];
   logic [31:0] cache_stamp [SLOTS];
   logic [31:0] use_count;

   lookup_result_type pending_lookups[$];
   lookup_result_type got_word, want_word;

   int error_count   = 0;
   int cycle_count   = 0;
   int words_sent    = 0;
   int words_checked = 0;
   int hits_seen     = 0;
   int evictions_seen = 0;
   int failed_fills_seen = 0;
   int burst_left    = 1;
   int ready_mode    = 0;
   int ready_hold    = 0;

   lru_tag_cache_lookup_unit #(.SLOTS(SLOTS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL lru_tag_cache_lookup_unit");
         $finish;
      end
   end

   // Looks the tag up, updates the cache copy and returns what the block should report.
   function automatic lookup_result_type predict_lookup(input logic [31:0] tag,
                                                        input logic fill_ok);
      lookup_result_type res;
      int             idx;
      logic           found;
      logic [31:0]    oldest;
      res   = '0;
      found = 1'b0;
      idx   = 0;
      for (int i = 0; i < SLOTS; i++) begin
         if (!found && cache_valid[i] && cache_tag[i] == tag) begin
            found = 1'b1;
            idx   = i;
         end
      end
      if (found) begin
         res.hit = 1'b1;
         cache_stamp[idx] = use_count;
         use_count++;
      end else begin
         for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!cache_valid[i]) begin
               found = 1'b1;
               idx   = i;
            end
         end
         if (!found) begin
            // full: strictly smallest stamp, lowest index on a tie
            idx    = 0;
            oldest = cache_stamp[0];
            for (int i = 1; i < SLOTS; i++) begin
               if (cache_stamp[i] < oldest) begin
                  oldest = cache_stamp[i];
                  idx    = i;
               end
            end
            res.evicted = 1'b1;
         end
         if (fill_ok) begin
            cache_valid[idx] = 1'b1;
            cache_tag[idx]   = tag;
            cache_stamp[idx] = use_count;
            use_count++;
         end else begin
            // old contents already released, so the slot goes empty
            cache_valid[idx] = 1'b0;
            res.status = 1'b1;
         end
      end
      res.slot = idx[2:0];
      return res;
   endfunction

   // Single process for both channels, so a result is always compared before
   // the word accepted on the same edge is predicted.
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) cache_valid[i] = 1'b0;
         use_count = '0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_word = rsp_tdata[5:0];
            if (rsp_tdata[7:6] != 2'b00)
               $error("pad: expected 0, got %0d", rsp_tdata[7:6]);
            if (pending_lookups.size() == 0) begin
               $error("unexpected result word %h", rsp_tdata);
               error_count++;
            end else begin
               want_word = pending_lookups.pop_front();
               words_checked++;
               if (got_word.hit !== want_word.hit) begin
                  $error("hit: expected %0d, got %0d", want_word.hit, got_word.hit);
                  error_count++;
               end
               if (got_word.slot !== want_word.slot) begin
                  $error("slot_index: expected %0d, got %0d", want_word.slot, got_word.slot);
                  error_count++;
               end
               if (got_word.evicted !== want_word.evicted) begin
                  $error("evicted: expected %0d, got %0d", want_word.evicted,
                         got_word.evicted);
                  error_count++;
               end
               if (got_word.status !== want_word.status) begin
                  $error("status: expected %0d, got %0d", want_word.status, got_word.status);
                  error_count++;
               end
            end
            if (rsp_tdata[7:6] != 2'b00) error_count++;
         end
         if (req_tvalid && req_tready) begin
            want_word = predict_lookup(req_tdata, req_tuser[0]);
            pending_lookups.push_back(want_word);
            if (want_word.hit) hits_seen++;
            if (want_word.evicted) evictions_seen++;
            if (want_word.status) failed_fills_seen++;
         end
      end
   end

   // Receiver: runs of always-ready, coin-flip and mostly-stalled.
   always @(negedge clock) begin
      if (ready_hold <= 0) begin
         ready_mode = $urandom_range(0, 3);
         ready_hold = $urandom_range(4, 40);
      end
      ready_hold--;
      case (ready_mode)
         0, 1: rsp_tready = 1'b1;
         2: rsp_tready = 1'($urandom_range(0, 1));
         default: rsp_tready = ($urandom_range(0, 4) == 0);
      endcase
   end

   // One word on the request channel; valid stays up within a burst.
   task automatic send_lookup(input logic [31:0] tag, input logic fill_ok);
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = tag;
      req_tuser  = fill_ok;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      words_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 12);
         repeat ($urandom_range(1, 6)) begin
            @(negedge clock);
            req_tvalid = 1'b0;
            req_tdata  = $urandom;
            req_tuser  = 1'($urandom_range(0, 1));
         end
      end
   endtask

   task automatic test_fill_and_hit;
      send_lookup(32'h0000_0000, 1'b1);    // empty cache, slot 0
      send_lookup(32'hFFFF_FFFF, 1'b1);    // slot 1
      send_lookup(32'h0000_0000, 1'b1);    // hit
      send_lookup(32'hFFFF_FFFF, 1'b0);    // hit, fill_ok ignored
      send_lookup(32'h5A5A_0001, 1'b0);    // failed fill into an empty slot
   endtask

   task automatic test_fill_to_capacity;
      for (int i = 0; i < SLOTS - 2; i++)
         send_lookup(32'h0000_0100 + i, 1'b1);
   endtask

   task automatic test_lru_replacement;
      send_lookup(32'h0000_0000, 1'b1);    // refresh slot 0
      send_lookup(32'h0000_0200, 1'b1);    // evicts the least recent
      send_lookup(32'h0000_0201, 1'b0);    // full cache, failed fill empties victim
      send_lookup(32'h0000_0202, 1'b1);    // reuses that empty slot
      send_lookup(32'hFFFF_FFFF, 1'b1);    // evicted earlier, misses again
   endtask

   // Mostly a small working set so hits and evictions mix, some stray tags.
   task automatic test_random_lookups;
      logic [31:0] tag_set[16];
      int          set_size;
      logic [31:0] tag;
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n % 150 == 0) begin
            set_size = $urandom_range(SLOTS - 2, 14);
            for (int i = 0; i < 16; i++) tag_set[i] = $urandom;
            if ($urandom_range(0, 1)) tag_set[0] = 32'h0000_0000;
            if ($urandom_range(0, 1)) tag_set[1] = 32'hFFFF_FFFF;
         end
         if ($urandom_range(0, 9) != 0)
            tag = tag_set[$urandom_range(0, set_size - 1)];
         else
            tag = $urandom;
         send_lookup(tag, $urandom_range(0, 6) != 0);
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_fill_and_hit();
      test_fill_to_capacity();
      test_lru_replacement();
      test_random_lookups();

      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_lookups.size() != 0) @(posedge clock);
      repeat (SLOTS + 6) @(posedge clock);

      $display("Sent %0d lookup words, checked %0d results.", words_sent, words_checked);
      $display("Hits %0d, evictions %0d, failed fills %0d.", hits_seen, evictions_seen,
               failed_fills_seen);
      if (error_count == 0)
         $display("PASS lru_tag_cache_lookup_unit");
      else
         $display("FAIL lru_tag_cache_lookup_unit");
      $finish;
   end

endmodule
